@@ hw/rtl/mme_pkg.sv @@
// shared types, constants and helpers of the matrix multiply engine
package mme_pkg;

   // element and sum widths
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int SUM_W    = 40;

   // item field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 5;
   localparam int DIM_W    = 6;

   // stream packing
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int ROW_LSB    = 0;
   localparam int COL_LSB    = ROW_LSB + INDEX_W;
   localparam int VALUE_LSB  = COL_LSB + INDEX_W;
   localparam int SUM_LSB    = INDEX_W;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // sizing
   localparam int MAX_DIM_DEF = 32;
   localparam int RESULT_CAP  = 32;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

   // item operations
   typedef enum logic [OP_W-1:0] {
      OP_LOAD_LEFT  = 2'd0,
      OP_LOAD_RIGHT = 2'd1,
      OP_ROW        = 2'd2
   } op_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_ROWS_USED  = 2'd0,
      REG_INNER_USED = 2'd1,
      REG_COLS_USED  = 2'd2
   } reg_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_HAND
   } seq_state_type;

   // one operand pair sent to the mac
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } issue_type;

   // a size register as used: zero acts as one, large values clamp to the limit
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/mme_ram.sv @@
// generic single write port, single read port ram with registered read
module mme_ram
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
)
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mme_mac.sv @@
// shared multiply-accumulate unit: product register then accumulator
module mme_mac
   import mme_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  issue_type               issue,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic                    done,
   output logic signed [SUM_W-1:0] sum
);

   issue_type               stage1_ff;
   issue_type               stage2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;
   logic                     done_ff;

   // control flags follow the ram read and the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= '0;
         stage2_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= issue;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff.valid & stage2_ff.last;
      end
   end

   // accumulate, restarting on the first term of a column
   always_comb begin
      if (stage2_ff.first) begin
         acc_in = SUM_W'(prod_ff);
      end else begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end
   end

   // product and accumulator registers
   always_ff @(posedge clock) begin
      if (stage1_ff.valid) begin
         prod_ff <= left_data * right_data;
      end
      if (stage2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

@@ hw/rtl/mme_seq.sv @@
// sequencer: load decode, operand address generation and result register
module mme_seq
   import mme_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [DIM_W-1:0]                     rows_used,
   input  logic [DIM_W-1:0]                     inner_used,
   input  logic [DIM_W-1:0]                     cols_used,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [OP_W-1:0]                      req_tuser,
   input  logic [REQ_DATA_W-1:0]                req_tdata,
   output logic                                 left_we,
   output logic                                 right_we,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   left_waddr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   right_waddr,
   output logic [DATA_W-1:0]                    wdata,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   left_raddr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   right_raddr,
   output issue_type                            issue,
   input  logic                                 mac_done,
   input  logic signed [SUM_W-1:0]              mac_sum,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_DATA_W-1:0]                rsp_tdata,
   output logic                                 rsp_tlast
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int LIM    = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;
   localparam int CNT_W  = $clog2(LIM);

   seq_state_type          state_ff, state_in;
   logic [INDEX_W-1:0]     row_ff, row_in;
   logic [CNT_W-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]       term_ff, term_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_load;
   logic [INDEX_W-1:0]     out_col_ff;
   logic signed [SUM_W-1:0] out_sum_ff;
   logic                   out_last_ff;

   logic [DIM_W-1:0]       m_eff, k_eff, n_eff;
   logic                   accept;
   logic [INDEX_W-1:0]     req_row, req_col;
   logic [DIM_W-1:0]       req_row_x, req_col_x;
   logic                   term_last, col_last;

   // sizes in use
   assign m_eff = eff_dim(rows_used, DIM_W'(LIM));
   assign k_eff = eff_dim(inner_used, DIM_W'(LIM));
   assign n_eff = eff_dim(cols_used, DIM_W'(LIM));

   // item fields
   assign req_row   = req_tdata[ROW_LSB +: INDEX_W];
   assign req_col   = req_tdata[COL_LSB +: INDEX_W];
   assign wdata     = req_tdata[VALUE_LSB +: DATA_W];
   assign req_row_x = DIM_W'(req_row);
   assign req_col_x = DIM_W'(req_col);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   // load decode with range checks
   always_comb begin
      left_we  = 1'b0;
      right_we = 1'b0;
      case (req_tuser)
         OP_LOAD_LEFT: begin
            left_we = accept & (req_row_x < m_eff) & (req_col_x < k_eff);
         end
         OP_LOAD_RIGHT: begin
            right_we = accept & (req_row_x < k_eff) & (req_col_x < n_eff);
         end
         default: begin
         end
      endcase
   end

   assign left_waddr  = ADDR_W'(req_row) * ADDR_W'(MAX_DIM) + ADDR_W'(req_col);
   assign right_waddr = left_waddr;

   // operand addresses: left walks the row, right walks the column
   assign left_raddr  = ADDR_W'(row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(term_ff);
   assign right_raddr = ADDR_W'(term_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(col_ff);

   assign term_last = (DIM_W'(term_ff) == k_eff - DIM_W'(1));
   assign col_last  = (DIM_W'(col_ff) == n_eff - DIM_W'(1));

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      term_in      = term_ff;
      issue        = '0;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser == OP_ROW && req_row_x < m_eff) begin
               row_in   = req_row;
               col_in   = '0;
               term_in  = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            issue.valid = 1'b1;
            issue.first = (term_ff == '0);
            issue.last  = term_last;
            if (term_last) begin
               term_in  = '0;
               state_in = S_DRAIN;
            end else begin
               term_in = term_ff + CNT_W'(1);
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_HAND;
            end
         end
         S_HAND: begin
            if (!out_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (col_last) begin
                  state_in = S_IDLE;
               end else begin
                  col_in   = col_ff + CNT_W'(1);
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         col_ff       <= '0;
         term_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         col_ff       <= col_in;
         term_ff      <= term_in;
      end
   end

   // row latch and result register
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (out_load) begin
         out_col_ff  <= INDEX_W'(col_ff);
         out_sum_ff  <= mac_sum;
         out_last_ff <= col_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_sum_ff, out_col_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/matrix_multiply_engine_top.sv @@
// Matrix multiply engine C = A x B on signed Q8.8 elements with exact Q24.16
// sums. Items on req_ carry an operation in req_tuser: load an element of A,
// load an element of B (no result; loads outside the sizes in use are
// dropped), or compute one row of C, which returns one item per column in use
// on rsp_, in rising order, the last marked by rsp_tlast. One shared
// multiply-accumulate takes one term per cycle while a column is issued, fed
// by one read port on each element store, behind the ram read, product and
// accumulator registers, and each column then passes a hand-off state. A and
// B hold no defined value until written. Sizes are set over the csr_ port at
// byte addresses 0 (rows_used), 4 (inner_used) and 8 (cols_used); the user must
// set them only while the engine is idle, as the block itself does not enforce it.
module matrix_multiply_engine_top
   import mme_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,   // op
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row[4:0], col[9:5], value[25:10]
   // result item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_col[4:0], dot_sum[44:5]
   output logic                  rsp_tlast,   // last
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LIM    = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;

   logic [DIM_W-1:0]        rows_ff, inner_ff, cols_ff;
   logic                    csr_write;
   logic                    left_we, right_we;
   logic [ADDR_W-1:0]       left_waddr, right_waddr, left_raddr, right_raddr;
   logic [DATA_W-1:0]       wdata, left_rdata, right_rdata;
   issue_type               issue;
   logic                    mac_done;
   logic signed [SUM_W-1:0] mac_sum;

   // size registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_RESET;
         inner_ff <= DIM_RESET;
         cols_ff  <= DIM_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_ROWS_USED:  rows_ff  <= csr_pwdata[DIM_W-1:0];
            REG_INNER_USED: inner_ff <= csr_pwdata[DIM_W-1:0];
            REG_COLS_USED:  cols_ff  <= csr_pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[3:2])
         REG_ROWS_USED:  csr_prdata = CSR_DATA_W'(rows_ff);
         REG_INNER_USED: csr_prdata = CSR_DATA_W'(inner_ff);
         REG_COLS_USED:  csr_prdata = CSR_DATA_W'(cols_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer
   mme_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .rows_used   (rows_ff),
      .inner_used  (inner_ff),
      .cols_used   (cols_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .left_we     (left_we),
      .right_we    (right_we),
      .left_waddr  (left_waddr),
      .right_waddr (right_waddr),
      .wdata       (wdata),
      .left_raddr  (left_raddr),
      .right_raddr (right_raddr),
      .issue       (issue),
      .mac_done    (mac_done),
      .mac_sum     (mac_sum),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // element store for A
   mme_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (left_waddr),
      .wr_data (wdata),
      .rd_addr (left_raddr),
      .rd_data (left_rdata)
   );

   // element store for B
   mme_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (right_we),
      .wr_addr (right_waddr),
      .wr_data (wdata),
      .rd_addr (right_raddr),
      .rd_data (right_rdata)
   );

   // shared multiply-accumulate
   mme_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .left_data  ($signed(left_rdata)),
      .right_data ($signed(right_rdata)),
      .done       (mac_done),
      .sum        (mac_sum)
   );

`ifndef SYNTH
   // a column finishes only after its operands have all been issued
   a_done_not_during_issue: assert property (@(posedge clock) disable iff (reset)
      !(issue.valid && mac_done))
      else $error("mac finished a column while operands were still issued");

   // no new item is taken while operands are in flight
   a_no_accept_while_issuing: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !issue.valid)
      else $error("request accepted during operand issue");

   // the marked result is the final column in use
   a_last_is_final_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tdata[INDEX_W-1:0] ==
          INDEX_W'(eff_dim(cols_ff, DIM_W'(LIM)) - DIM_W'(1))))
      else $error("last result is not the final column");
`endif

endmodule

@@ dv/matrix_multiply_engine_top_tb.sv @@
// testbench of the matrix multiply engine: directed table, then random load and row traffic
module matrix_multiply_engine_top_tb
   import mme_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM = MAX_DIM_DEF;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int ITEM_GOAL = 480;
   localparam int RESULT_GOAL = 48;
   localparam int SETTLE_CYCLES = 64;
   localparam int IDLE_PCT = 22;
   localparam int PLAN_LEN = 33;

   // one element of C as it leaves the engine
   typedef struct packed {
      logic [INDEX_W-1:0]      col;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } c_elem_t;

   // one row of the directed table: a size write or an item
   typedef struct packed {
      logic                    is_csr;
      reg_index_type           reg_sel;
      logic [DIM_W-1:0]        size;
      logic [OP_W-1:0]         op;
      logic [INDEX_W-1:0]      row;
      logic [INDEX_W-1:0]      col;
      logic [DATA_W-1:0]       value;
      logic                    typed;
      logic signed [SUM_W-1:0] typed_sum;
   } plan_step_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser;   // op
   logic [REQ_DATA_W-1:0] req_tdata;   // row[4:0], col[9:5], value[25:10]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_col[4:0], dot_sum[44:5]
   logic                  rsp_tlast;   // last
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // mirror of the element stores and of the size registers
   logic [DATA_W-1:0] left_copy  [DIM][DIM];
   logic [DATA_W-1:0] right_copy [DIM][DIM];
   bit                left_set   [DIM][DIM];
   bit                right_set  [DIM][DIM];
   logic [DIM_W-1:0]  rows_reg  = DIM_RESET;
   logic [DIM_W-1:0]  inner_reg = DIM_RESET;
   logic [DIM_W-1:0]  cols_reg  = DIM_RESET;

   c_elem_t    c_elems_due [$];
   plan_step_t plan [PLAN_LEN];
   int         items_used   = 0;
   int         results_seen = 0;
   int         error_count  = 0;
   bit         steady       = 1'b0;

   matrix_multiply_engine_top u_dut (.*);

   always #5 clock = ~clock;

   // a size register as the engine uses it
   function automatic int dim_in_use(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      return (int'(v) > DIM) ? DIM : int'(v);
   endfunction

   // exact Q24.16 dot product of an A row and a B column over k terms
   function automatic logic signed [SUM_W-1:0] c_dot(input int r, input int j, input int k);
      longint acc = 0;
      for (int p = 0; p < k; p++) begin
         acc += longint'($signed(left_copy[r][p])) * longint'($signed(right_copy[p][j]));
      end
      return SUM_W'(acc);
   endfunction

   function automatic logic [DIM_W-1:0] extreme_size();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return DIM_W'(32);
         default: return DIM_W'($urandom_range(33, 63));
      endcase
   endfunction

   function automatic plan_step_t size_step(input reg_index_type sel, input int size);
      plan_step_t s = '0;
      s.is_csr  = 1'b1;
      s.reg_sel = sel;
      s.size    = DIM_W'(size);
      return s;
   endfunction

   function automatic plan_step_t item_step(input logic [OP_W-1:0] op, input int row,
                                            input int col, input logic [DATA_W-1:0] value);
      plan_step_t s = '0;
      s.op    = op;
      s.row   = INDEX_W'(row);
      s.col   = INDEX_W'(col);
      s.value = value;
      return s;
   endfunction

   // row request on a one-column C whose single element is known
   function automatic plan_step_t typed_row(input int row, input longint sum);
      plan_step_t s = item_step(OP_ROW, row, 0, '0);
      s.typed     = 1'b1;
      s.typed_sum = SUM_W'(sum);
      return s;
   endfunction

   // append one element of C to the queue of those still due
   function automatic void add_due(input c_elem_t e);
      c_elems_due = {c_elems_due, e};
   endfunction

   // predictor: updates the store mirror and queues the elements of C a row request gives
   task automatic apply_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] row,
                             input logic [INDEX_W-1:0] col, input logic [DATA_W-1:0] value,
                             input bit predict);
      int m = dim_in_use(rows_reg);
      int k = dim_in_use(inner_reg);
      int n = dim_in_use(cols_reg);
      c_elem_t e;
      case (op)
         OP_LOAD_LEFT: begin
            if (int'(row) < m && int'(col) < k) begin
               left_copy[row][col] = value;
               left_set[row][col]  = 1'b1;
               items_used++;
            end
         end
         OP_LOAD_RIGHT: begin
            if (int'(row) < k && int'(col) < n) begin
               right_copy[row][col] = value;
               right_set[row][col]  = 1'b1;
               items_used++;
            end
         end
         OP_ROW: begin
            if (int'(row) < m) begin
               items_used++;
               for (int j = 0; j < n && predict; j++) begin
                  e.col  = INDEX_W'(j);
                  e.sum  = c_dot(int'(row), j, k);
                  e.last = (j == n - 1);
                  add_due(e);
               end
            end
         end
         default: ;
      endcase
   endtask

   // one request item, with random gaps unless in a steady stretch
   task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] row,
                            input logic [INDEX_W-1:0] col, input logic [DATA_W-1:0] value,
                            input bit predict);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({value, col, row});
      do @(posedge clock); while (!req_tready);
      apply_item(op, row, col, value, predict);
   endtask

   // write every store entry a row request will read that holds nothing yet
   task automatic fill_for_row(input int r);
      int k = dim_in_use(inner_reg);
      int n = dim_in_use(cols_reg);
      for (int p = 0; p < k; p++) begin
         if (!left_set[r][p])
            send_item(OP_LOAD_LEFT, INDEX_W'(r), INDEX_W'(p), DATA_W'($urandom), 1'b1);
      end
      for (int p = 0; p < k; p++) begin
         for (int j = 0; j < n; j++) begin
            if (!right_set[p][j])
               send_item(OP_LOAD_RIGHT, INDEX_W'(p), INDEX_W'(j), DATA_W'($urandom), 1'b1);
         end
      end
   endtask

   // hold the sender until all of C has come back and the engine has gone quiet
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (c_elems_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_size(input reg_index_type sel, input logic [DIM_W-1:0] size);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(sel));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(size)) begin
         $error("%s: expected %0d, got %0d", sel.name(), size, got);
         error_count++;
      end
   endtask

   task automatic write_size(input reg_index_type sel, input logic [DIM_W-1:0] size);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata  <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (sel)
         REG_ROWS_USED:  rows_reg  = size;
         REG_INNER_USED: inner_reg = size;
         REG_COLS_USED:  cols_reg  = size;
         default: ;
      endcase
      check_size(sel, size);
   endtask

   // result side: random stalls and in-order comparison
   always @(posedge clock) begin
      c_elem_t due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (c_elems_due.size() == 0) begin
            $error("unexpected result item: out_col %0d dot_sum %0d",
                   rsp_tdata[INDEX_W-1:0], $signed(rsp_tdata[SUM_LSB +: SUM_W]));
            error_count++;
         end else begin
            due = c_elems_due.pop_front();
            if (rsp_tdata[INDEX_W-1:0] !== due.col) begin
               $error("out_col: expected %0d, got %0d", due.col, rsp_tdata[INDEX_W-1:0]);
               error_count++;
            end
            if ($signed(rsp_tdata[SUM_LSB +: SUM_W]) !== due.sum) begin
               $error("dot_sum: expected %0d, got %0d", due.sum,
                      $signed(rsp_tdata[SUM_LSB +: SUM_W]));
               error_count++;
            end
            if (rsp_tlast !== due.last) begin
               $error("last: expected %0d, got %0d", due.last, rsp_tlast);
               error_count++;
            end
         end
      end
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // stimulus
   initial begin
      int phase;
      int mode;
      int m;
      int k;
      int n;
      int r;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] row;
      logic [DIM_W-1:0]   rows_pick;
      logic [DIM_W-1:0]   inner_pick;
      logic [DIM_W-1:0]   cols_pick;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      foreach (left_copy[i, j]) begin
         left_copy[i][j]  = '0;
         right_copy[i][j] = '0;
      end

      // directed: extremes of Q8.8, ignored loads and requests, spare op, size clamping
      plan = '{
         size_step(REG_ROWS_USED, 1),
         size_step(REG_INNER_USED, 1),
         size_step(REG_COLS_USED, 1),
         item_step(OP_LOAD_LEFT, 0, 0, 16'h7FFF),
         item_step(OP_LOAD_RIGHT, 0, 0, 16'h7FFF),
         typed_row(0, 64'sd1073676289),
         item_step(OP_LOAD_LEFT, 0, 0, 16'h8000),
         item_step(OP_LOAD_RIGHT, 0, 0, 16'h8000),
         typed_row(0, 64'sd1073741824),
         item_step(OP_LOAD_RIGHT, 0, 0, 16'h7FFF),
         typed_row(0, -64'sd1073709056),
         item_step(OP_LOAD_LEFT, 0, 1, 16'h1234),
         item_step(OP_LOAD_LEFT, 1, 0, 16'h1234),
         item_step(OP_LOAD_RIGHT, 1, 0, 16'h1234),
         item_step(OP_LOAD_RIGHT, 0, 1, 16'h1234),
         item_step(OP_ROW, 1, 0, 16'h0000),
         item_step(OP_SPARE, 0, 0, 16'hFFFF),
         typed_row(0, -64'sd1073709056),
         size_step(REG_ROWS_USED, 0),
         size_step(REG_INNER_USED, 0),
         size_step(REG_COLS_USED, 0),
         typed_row(0, -64'sd1073709056),
         item_step(OP_LOAD_LEFT, 0, 0, 16'h0000),
         typed_row(0, 64'sd0),
         size_step(REG_ROWS_USED, 2),
         size_step(REG_INNER_USED, 2),
         size_step(REG_COLS_USED, 2),
         item_step(OP_LOAD_RIGHT, 0, 1, 16'h7FFF),
         item_step(OP_LOAD_RIGHT, 1, 0, 16'h8000),
         item_step(OP_LOAD_RIGHT, 1, 1, 16'h8000),
         item_step(OP_LOAD_LEFT, 1, 0, 16'h8000),
         item_step(OP_LOAD_LEFT, 1, 1, 16'h8000),
         item_step(OP_ROW, 1, 31, 16'hFFFF)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // sizes after reset
      for (int i = 0; i <= int'(REG_COLS_USED); i++) check_size(reg_index_type'(i), DIM_RESET);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle_idle();
            write_size(plan[i].reg_sel, plan[i].size);
         end else begin
            send_item(plan[i].op, plan[i].row, plan[i].col, plan[i].value, !plan[i].typed);
            if (plan[i].typed) add_due('{'0, plan[i].typed_sum, 1'b1});
         end
      end

      // random phases, each with its own sizes; the first three force the largest sizes
      phase = 0;
      while (items_used < ITEM_GOAL || results_seen < RESULT_GOAL) begin
         rows_pick  = DIM_W'($urandom_range(1, 8));
         inner_pick = DIM_W'($urandom_range(1, 6));
         cols_pick  = DIM_W'($urandom_range(1, 8));
         mode = (phase < 3) ? phase : $urandom_range(0, 5);
         case (mode)
            0: rows_pick = (phase == 0) ? DIM_W'(63) : extreme_size();
            1: begin
               inner_pick = (phase == 1) ? DIM_W'(32) : extreme_size();
               cols_pick  = DIM_W'($urandom_range(1, 2));
            end
            2: begin
               cols_pick  = (phase == 2) ? DIM_W'(32) : extreme_size();
               inner_pick = DIM_W'($urandom_range(1, 2));
            end
            default: ;
         endcase
         settle_idle();
         write_size(REG_ROWS_USED, rows_pick);
         write_size(REG_INNER_USED, inner_pick);
         write_size(REG_COLS_USED, cols_pick);
         steady = (phase % 4 == 3);
         m = dim_in_use(rows_reg);
         k = dim_in_use(inner_reg);
         n = dim_in_use(cols_reg);

         repeat ($urandom_range(6, 14)) begin
            if ($urandom_range(99) < 75) begin
               // well-formed: fresh A row, some fresh B entries, then the row request
               r = $urandom_range(0, m - 1);
               for (int p = 0; p < k; p++) begin
                  if (k <= 8 || $urandom_range(0, 7) == 0)
                     send_item(OP_LOAD_LEFT, INDEX_W'(r), INDEX_W'(p), DATA_W'($urandom),
                               1'b1);
               end
               repeat ($urandom_range(0, 4))
                  send_item(OP_LOAD_RIGHT, INDEX_W'($urandom_range(0, k - 1)),
                            INDEX_W'($urandom_range(0, n - 1)), DATA_W'($urandom), 1'b1);
               fill_for_row(r);
               send_item(OP_ROW, INDEX_W'(r), INDEX_W'($urandom), DATA_W'($urandom), 1'b1);
            end else begin
               // noise over the whole field ranges, spare op included
               op  = OP_W'($urandom_range(0, 3));
               row = INDEX_W'($urandom);
               if (op == OP_ROW && int'(row) < m) fill_for_row(int'(row));
               send_item(op, row, INDEX_W'($urandom), DATA_W'($urandom), 1'b1);
            end
         end
         phase++;
      end
      steady = 1'b0;

      settle_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ matrix_multiply_engine_top.f @@
hw/rtl/mme_pkg.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_mac.sv
hw/rtl/mme_seq.sv
hw/rtl/matrix_multiply_engine_top.sv
dv/matrix_multiply_engine_top_tb.sv
